// ===== hdl/ecc_pkg.sv =====
// Shared constants for the elastic circle collision pipeline.
package ecc_pkg;

	// Radius, radius sum and centre-line length widths
	localparam int RAD_W = 16;
	localparam int SUM_W = RAD_W + 1;
	localparam int LEN_W = SUM_W;

	// Offset width while the circles are in contact (|d| <= radius sum)
	localparam int DX_W = SUM_W + 1;

	// Square root input: squared distance, bounded by the squared radius sum
	localparam int SQ_IN_W = 2 * SUM_W;
	localparam int SQ_LAT = SQ_IN_W / 2;

	// Restitution: register width, unity value and scaled factor width
	localparam int E_W = 9;
	localparam int E_SHIFT = 8;
	localparam logic [E_W-1:0] E_ONE = E_W'(1 << E_SHIFT);
	localparam int K_W = E_SHIFT + 2;

endpackage

// ===== hdl/ecc_delay.sv =====
// Fixed-length delay line that advances with the pipeline enable.
module ecc_delay #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] pipe_s [N];

	// Shift the item one tap per enabled cycle
	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= din;
			for (int i = 1; i < N; i++) begin
				pipe_s[i] <= pipe_s[i-1];
			end
		end
	end

	assign dout = pipe_s[N-1];

endmodule

// ===== hdl/ecc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module ecc_sqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [ecc_pkg::SQ_IN_W-1:0] din,
	output logic [ecc_pkg::LEN_W-1:0]   dout
);
	import ecc_pkg::*;

	localparam int REM_W = LEN_W + 2;
	localparam int TRY_W = REM_W + 2;

	logic [SQ_IN_W-1:0] x_s   [SQ_LAT];
	logic [LEN_W-1:0]   r_s   [SQ_LAT];
	logic [REM_W-1:0]   rem_s [SQ_LAT];

	logic [SQ_IN_W-1:0] x_in   [SQ_LAT];
	logic [LEN_W-1:0]   r_in   [SQ_LAT];
	logic [REM_W-1:0]   rem_in [SQ_LAT];
	logic [TRY_W-1:0]   try_c  [SQ_LAT];
	logic [TRY_W-1:0]   trial_c[SQ_LAT];
	logic [SQ_IN_W-1:0] x_nx   [SQ_LAT];
	logic [LEN_W-1:0]   r_nx   [SQ_LAT];
	logic [REM_W-1:0]   rem_nx [SQ_LAT];

	// Bring down two radicand bits per stage and try the next root bit
	always_comb begin
		for (int i = 0; i < SQ_LAT; i++) begin
			if (i == 0) begin
				x_in[i]   = din;
				r_in[i]   = '0;
				rem_in[i] = '0;
			end else begin
				x_in[i]   = x_s[i-1];
				r_in[i]   = r_s[i-1];
				rem_in[i] = rem_s[i-1];
			end
			try_c[i]   = {rem_in[i], x_in[i][SQ_IN_W-1 -: 2]};
			trial_c[i] = TRY_W'({r_in[i], 2'b01});
			x_nx[i]    = x_in[i] << 2;
			if (try_c[i] >= trial_c[i]) begin
				rem_nx[i] = REM_W'(try_c[i] - trial_c[i]);
				r_nx[i]   = {r_in[i][LEN_W-2:0], 1'b1};
			end else begin
				rem_nx[i] = REM_W'(try_c[i]);
				r_nx[i]   = {r_in[i][LEN_W-2:0], 1'b0};
			end
		end
	end

	// Advance all stages together
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < SQ_LAT; i++) begin
				x_s[i]   <= x_nx[i];
				r_s[i]   <= r_nx[i];
				rem_s[i] <= rem_nx[i];
			end
		end
	end

	assign dout = r_s[SQ_LAT-1];

endmodule

// ===== hdl/ecc_div.sv =====
// Pipelined signed divider by a positive divisor, rounding to nearest, ties away from zero.
module ecc_div #(
	parameter int NW = 32,
	parameter int DW = 16,
	parameter int QW = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [NW:0] num,
	input  logic [DW-1:0]      den,
	output logic signed [QW:0] quo
);

	localparam int AW = NW + 2;

	logic signed [AW-1:0] ext_c;
	logic [AW-1:0]        mag_c;
	logic [AW-1:0]        adj_c;

	logic [DW-1:0] rem_s  [QW+1];
	logic [QW-1:0] work_s [QW+1];
	logic [DW-1:0] den_s  [QW+1];
	logic          neg_s  [QW+1];
	logic [QW:0]   quo_s;

	logic [DW:0]   try_c [QW+1];
	logic          ge_c  [QW+1];
	logic [DW-1:0] rem_c [QW+1];
	logic [QW-1:0] work_c[QW+1];

	// Take the magnitude and add half the divisor for rounding
	always_comb begin
		ext_c = {num[NW], num};
		mag_c = num[NW] ? AW'(-ext_c) : AW'(ext_c);
		adj_c = mag_c + AW'(den >> 1);
	end

	// One restoring step per stage: shift in a dividend bit, subtract if it fits
	always_comb begin
		try_c[0]  = '0;
		ge_c[0]   = 1'b0;
		rem_c[0]  = '0;
		work_c[0] = '0;
		for (int k = 1; k <= QW; k++) begin
			try_c[k]  = {rem_s[k-1], work_s[k-1][QW-1]};
			ge_c[k]   = try_c[k] >= {1'b0, den_s[k-1]};
			rem_c[k]  = ge_c[k] ? DW'(try_c[k] - {1'b0, den_s[k-1]}) : try_c[k][DW-1:0];
			work_c[k] = {work_s[k-1][QW-2:0], ge_c[k]};
		end
	end

	// Advance input, step and output stages
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= DW'(adj_c >> QW);
			work_s[0] <= adj_c[QW-1:0];
			den_s[0]  <= den;
			neg_s[0]  <= num[NW];
			for (int k = 1; k <= QW; k++) begin
				rem_s[k]  <= rem_c[k];
				work_s[k] <= work_c[k];
				den_s[k]  <= den_s[k-1];
				neg_s[k]  <= neg_s[k-1];
			end
			quo_s <= neg_s[QW] ? -{1'b0, work_s[QW]} : {1'b0, work_s[QW]};
		end
	end

	assign quo = $signed(quo_s);

endmodule

// ===== hdl/ecc_outbuf.sv =====
// Two-entry output buffer that parts the pipeline from the downstream handshake.
module ecc_outbuf #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         room,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [W-1:0] m_tdata
);

	logic [1:0]   cnt_q;
	logic         wp_q;
	logic         rp_q;
	logic [W-1:0] mem_q [2];
	logic         pop;

	assign room     = cnt_q != 2'd2;
	assign m_tvalid = cnt_q != 2'd0;
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = mem_q[rp_q];

	// Track fill level and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			cnt_q <= 2'(cnt_q + 2'(push) - 2'(pop));
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
		end
	end

	// Store the arriving item
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

endmodule

// ===== hdl/elastic_circle_collision.sv =====
// Top level: two-circle contact resolution as a stallable deep pipeline.
//
// Use: present one circle pair per item on the s_ group; s_tdata packs both circles.
// One result item per input item appears on the m_ group in input order, with a
// collided flag and the corrected positions and velocities of both circles.
// The restitution register is written over cfg_valid/cfg_data, always ready,
// and must only change while no item is in flight.
// Throughput: one item per cycle while the output buffer has room. Each item passes
// through the 17-stage square root and three chained bit-per-stage dividers (impulse,
// mass split, projection and push-apart) on its way from accept to m_tvalid.
// The whole pipeline advances on one enable; a two-entry output buffer keeps
// s_tready high while one finished item waits, so input stalls whenever the
// buffer is full, whatever the receiver does with m_tready. Nothing is lost or repeated.
// Reset clears the valid bits and the buffer, and sets restitution to fully elastic.
module elastic_circle_collision #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius, b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius
	input  logic [8*COORD_WIDTH+31:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// collided, new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y,
	// new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y, zero fill
	output logic [8*COORD_WIDTH+7:0]    m_tdata,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ecc_pkg::E_W-1:0]     cfg_data
);
	import ecc_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int WW    = CW + 2;
	localparam int DVW   = CW + 1;
	localparam int PXW   = DX_W + DVW;
	localparam int PW    = PXW + 1;
	localparam int RAW_W = 8 * CW;
	localparam int QI    = CW + 3;
	localparam int QV    = CW + 4;
	localparam int D1    = QI + 2;
	localparam int D2    = QV + 2;
	localparam int NLAT  = 3 + SQ_LAT + 1 + D1 + 1 + D1 + 1 + D2;
	localparam int OW    = 8 * CW + 8;
	localparam int FW    = CW + 6;
	localparam int IMP_NW = PW + K_W;
	localparam int IMP_DW = LEN_W + E_SHIFT;
	localparam int J_NW   = QI + 1 + SUM_W - 1;
	localparam int V_NW   = DX_W + QI;
	localparam int SH_NW  = 2 * DX_W - 1;
	localparam int WA = RAW_W + 2*RAD_W + 2*DX_W + SUM_W + 1 + PW + K_W;
	localparam int WB = RAW_W + 2*RAD_W + 2*DX_W + SUM_W + 1 + LEN_W + SUM_W;
	localparam int WC = RAW_W + 2*DX_W + 1 + LEN_W + SUM_W;
	localparam int WD = RAW_W + 1;

	function automatic logic [CW-1:0] sat_c(input logic signed [FW-1:0] v);
		logic signed [FW-1:0] hi;
		logic signed [FW-1:0] lo;
		hi = $signed({{(FW-CW+1){1'b0}}, {(CW-1){1'b1}}});
		lo = ~hi;
		if (v > hi) begin
			return hi[CW-1:0];
		end else if (v < lo) begin
			return lo[CW-1:0];
		end
		return v[CW-1:0];
	endfunction

	// Configuration and flow control
	logic [E_W-1:0]  rest_q;
	logic            en;
	logic            acc;
	logic [NLAT-1:0] vld_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = en;
	assign acc       = s_tvalid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q <= E_ONE;
		end else if (cfg_valid) begin
			rest_q <= cfg_data;
		end
	end

	// Carry valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NLAT-2:0], acc};
		end
	end

	// Unpack the input item
	logic [CW-1:0]    apx, apy, avx, avy, bpx, bpy, bvx, bvy;
	logic [RAD_W-1:0] ra, rb;
	assign apx = s_tdata[0*CW +: CW];
	assign apy = s_tdata[1*CW +: CW];
	assign avx = s_tdata[2*CW +: CW];
	assign avy = s_tdata[3*CW +: CW];
	assign ra  = s_tdata[4*CW +: RAD_W];
	assign bpx = s_tdata[4*CW+RAD_W +: CW];
	assign bpy = s_tdata[5*CW+RAD_W +: CW];
	assign bvx = s_tdata[6*CW+RAD_W +: CW];
	assign bvy = s_tdata[7*CW+RAD_W +: CW];
	assign rb  = s_tdata[8*CW+RAD_W +: RAD_W];

	// Stage 1: offsets, radius sum, coarse range test, restitution factor
	logic signed [WW-1:0]  dx_c, dy_c, sw_c;
	logic signed [DVW-1:0] dvx_c, dvy_c;
	logic [SUM_W-1:0]      sum_c;
	logic                  inr_c;
	logic [K_W-1:0]        k_c;

	always_comb begin
		dx_c  = {{2{bpx[CW-1]}}, bpx} - {{2{apx[CW-1]}}, apx};
		dy_c  = {{2{bpy[CW-1]}}, bpy} - {{2{apy[CW-1]}}, apy};
		dvx_c = {bvx[CW-1], bvx} - {avx[CW-1], avx};
		dvy_c = {bvy[CW-1], bvy} - {avy[CW-1], avy};
		sum_c = {1'b0, ra} + {1'b0, rb};
		sw_c  = $signed({{(WW-SUM_W){1'b0}}, sum_c});
		inr_c = (dx_c <= sw_c) && (dx_c >= -sw_c) && (dy_c <= sw_c) && (dy_c >= -sw_c);
		if (rest_q > E_ONE) begin
			k_c = K_W'(E_ONE) + K_W'(E_ONE);
		end else begin
			k_c = K_W'(E_ONE) + K_W'(rest_q);
		end
	end

	logic [RAW_W-1:0]       raw_s1, raw_s2, raw_s3;
	logic [RAD_W-1:0]       ra_s1, rb_s1, ra_s2, rb_s2, ra_s3, rb_s3;
	logic signed [DX_W-1:0] dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3;
	logic [SUM_W-1:0]       sum_s1, sum_s2, sum_s3;
	logic signed [DVW-1:0]  dvx_s1, dvy_s1;
	logic                   inr_s1, inr_s2;
	logic [K_W-1:0]         k_s1, k_s2, k_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1 <= {bvy, bvx, bpy, bpx, avy, avx, apy, apx};
			ra_s1  <= ra;
			rb_s1  <= rb;
			dx_s1  <= dx_c[DX_W-1:0];
			dy_s1  <= dy_c[DX_W-1:0];
			sum_s1 <= sum_c;
			dvx_s1 <= dvx_c;
			dvy_s1 <= dvy_c;
			inr_s1 <= inr_c;
			k_s1   <= k_c;
		end
	end

	// Stage 2: squares and velocity projections
	logic signed [2*DX_W-1:0] dx2_c, dy2_c;
	logic [SQ_IN_W-1:0]       ss_c;
	logic signed [PXW-1:0]    px_c, py_c;
	logic [2*DX_W-2:0]        dx2_s2, dy2_s2;
	logic [SQ_IN_W-1:0]       ss_s2;
	logic signed [PXW-1:0]    px_s2, py_s2;

	always_comb begin
		dx2_c = dx_s1 * dx_s1;
		dy2_c = dy_s1 * dy_s1;
		ss_c  = sum_s1 * sum_s1;
		px_c  = dx_s1 * dvx_s1;
		py_c  = dy_s1 * dvy_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s2 <= raw_s1;
			ra_s2  <= ra_s1;
			rb_s2  <= rb_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			sum_s2 <= sum_s1;
			inr_s2 <= inr_s1;
			k_s2   <= k_s1;
			dx2_s2 <= dx2_c[2*DX_W-2:0];
			dy2_s2 <= dy2_c[2*DX_W-2:0];
			ss_s2  <= ss_c;
			px_s2  <= px_c;
			py_s2  <= py_c;
		end
	end

	// Stage 3: exact contact test, square root operand, projected closing speed
	logic [2*DX_W-1:0]  dist2_c;
	logic               coll_c;
	logic               coll_s3;
	logic [SQ_IN_W-1:0] sqin_s3;
	logic signed [PW-1:0] p_s3;

	always_comb begin
		dist2_c = {1'b0, dx2_s2} + {1'b0, dy2_s2};
		coll_c  = inr_s2 && (dist2_c != '0) &&
			(dist2_c <= {{(2*DX_W-SQ_IN_W){1'b0}}, ss_s2});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s3  <= raw_s2;
			ra_s3   <= ra_s2;
			rb_s3   <= rb_s2;
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			sum_s3  <= sum_s2;
			k_s3    <= k_s2;
			coll_s3 <= coll_c;
			sqin_s3 <= coll_c ? dist2_c[SQ_IN_W-1:0] : SQ_IN_W'(1);
			p_s3    <= {px_s2[PXW-1], px_s2} + {py_s2[PXW-1], py_s2};
		end
	end

	// Square root of the squared distance, sideband delayed alongside
	logic [LEN_W-1:0] len_a;
	logic [WA-1:0]    sba_out;
	logic [RAW_W-1:0] raw_a;
	logic [RAD_W-1:0] ra_a, rb_a;
	logic signed [DX_W-1:0] dx_a, dy_a;
	logic [SUM_W-1:0] sum_a;
	logic             coll_a;
	logic signed [PW-1:0] p_a;
	logic [K_W-1:0]   k_a;

	ecc_sqrt u_sqrt (
		.clk (clk),
		.en  (en),
		.din (sqin_s3),
		.dout(len_a)
	);

	ecc_delay #(.W(WA), .N(SQ_LAT)) u_dly_a (
		.clk (clk),
		.en  (en),
		.din ({raw_s3, ra_s3, rb_s3, dx_s3, dy_s3, sum_s3, coll_s3, p_s3, k_s3}),
		.dout(sba_out)
	);
	assign {raw_a, ra_a, rb_a, dx_a, dy_a, sum_a, coll_a, p_a, k_a} = sba_out;

	// Stage A: impulse numerator and denominator, overlap
	logic signed [IMP_NW:0] nimp_sA;
	logic [IMP_DW-1:0]      dimp_sA;
	logic [SUM_W-1:0]       sh_sA;
	logic [LEN_W-1:0]       len_sA;
	logic [RAW_W-1:0]       raw_sA;
	logic [RAD_W-1:0]       ra_sA, rb_sA;
	logic signed [DX_W-1:0] dx_sA, dy_sA;
	logic [SUM_W-1:0]       sum_sA;
	logic                   coll_sA;
	logic signed [IMP_NW:0] nimp_c;

	assign nimp_c = p_a * $signed({1'b0, k_a});

	always_ff @(posedge clk) begin
		if (en) begin
			nimp_sA <= nimp_c;
			dimp_sA <= {len_a, {E_SHIFT{1'b0}}};
			sh_sA   <= sum_a - len_a;
			len_sA  <= len_a;
			raw_sA  <= raw_a;
			ra_sA   <= ra_a;
			rb_sA   <= rb_a;
			dx_sA   <= dx_a;
			dy_sA   <= dy_a;
			sum_sA  <= sum_a;
			coll_sA <= coll_a;
		end
	end

	logic signed [QI:0] imp_b;
	logic [WB-1:0]      sbb_out;
	logic [RAW_W-1:0]   raw_b;
	logic [RAD_W-1:0]   ra_b, rb_b;
	logic signed [DX_W-1:0] dx_b, dy_b;
	logic [SUM_W-1:0]   sum_b, sh_b;
	logic               coll_b;
	logic [LEN_W-1:0]   len_b;

	ecc_div #(.NW(IMP_NW), .DW(IMP_DW), .QW(QI)) u_div_imp (
		.clk(clk), .en(en), .num(nimp_sA), .den(dimp_sA), .quo(imp_b)
	);

	ecc_delay #(.W(WB), .N(D1)) u_dly_b (
		.clk (clk),
		.en  (en),
		.din ({raw_sA, ra_sA, rb_sA, dx_sA, dy_sA, sum_sA, coll_sA, len_sA, sh_sA}),
		.dout(sbb_out)
	);
	assign {raw_b, ra_b, rb_b, dx_b, dy_b, sum_b, coll_b, len_b, sh_b} = sbb_out;

	// Stage B: split the impulse by mass
	logic signed [J_NW:0]   nja_c, njb_c;
	logic signed [J_NW:0]   nja_sB, njb_sB;
	logic [SUM_W-1:0]       sum_sB, sh_sB;
	logic [LEN_W-1:0]       len_sB;
	logic [RAW_W-1:0]       raw_sB;
	logic signed [DX_W-1:0] dx_sB, dy_sB;
	logic                   coll_sB;

	assign nja_c = imp_b * $signed({1'b0, rb_b});
	assign njb_c = imp_b * $signed({1'b0, ra_b});

	always_ff @(posedge clk) begin
		if (en) begin
			nja_sB  <= nja_c;
			njb_sB  <= njb_c;
			sum_sB  <= sum_b;
			sh_sB   <= sh_b;
			len_sB  <= len_b;
			raw_sB  <= raw_b;
			dx_sB   <= dx_b;
			dy_sB   <= dy_b;
			coll_sB <= coll_b;
		end
	end

	logic signed [QI:0] ja_c, jb_c;
	logic [WC-1:0]      sbc_out;
	logic [RAW_W-1:0]   raw_cc;
	logic signed [DX_W-1:0] dx_cc, dy_cc;
	logic               coll_cc;
	logic [LEN_W-1:0]   len_cc;
	logic [SUM_W-1:0]   sh_cc;

	ecc_div #(.NW(J_NW), .DW(SUM_W), .QW(QI)) u_div_ja (
		.clk(clk), .en(en), .num(nja_sB), .den(sum_sB), .quo(ja_c)
	);

	ecc_div #(.NW(J_NW), .DW(SUM_W), .QW(QI)) u_div_jb (
		.clk(clk), .en(en), .num(njb_sB), .den(sum_sB), .quo(jb_c)
	);

	ecc_delay #(.W(WC), .N(D1)) u_dly_c (
		.clk (clk),
		.en  (en),
		.din ({raw_sB, dx_sB, dy_sB, coll_sB, len_sB, sh_sB}),
		.dout(sbc_out)
	);
	assign {raw_cc, dx_cc, dy_cc, coll_cc, len_cc, sh_cc} = sbc_out;

	// Stage C: project the exchanges and the push-apart onto the axes
	logic signed [V_NW:0]  nvax_c, nvay_c, nvbx_c, nvby_c;
	logic signed [SH_NW:0] nsx_c, nsy_c;
	logic signed [V_NW:0]  nvax_sC, nvay_sC, nvbx_sC, nvby_sC;
	logic signed [SH_NW:0] nsx_sC, nsy_sC;
	logic [LEN_W-1:0]      len_sC;
	logic [LEN_W:0]        len2_sC;
	logic [RAW_W-1:0]      raw_sC;
	logic                  coll_sC;

	always_comb begin
		nvax_c = dx_cc * ja_c;
		nvay_c = dy_cc * ja_c;
		nvbx_c = dx_cc * jb_c;
		nvby_c = dy_cc * jb_c;
		nsx_c  = dx_cc * $signed({1'b0, sh_cc});
		nsy_c  = dy_cc * $signed({1'b0, sh_cc});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nvax_sC <= nvax_c;
			nvay_sC <= nvay_c;
			nvbx_sC <= nvbx_c;
			nvby_sC <= nvby_c;
			nsx_sC  <= nsx_c;
			nsy_sC  <= nsy_c;
			len_sC  <= len_cc;
			len2_sC <= {len_cc, 1'b0};
			raw_sC  <= raw_cc;
			coll_sC <= coll_cc;
		end
	end

	logic signed [QV:0] dvax_d, dvay_d, dvbx_d, dvby_d, shx_d, shy_d;
	logic [WD-1:0]      sbd_out;
	logic [RAW_W-1:0]   raw_d;
	logic               coll_d;

	ecc_div #(.NW(V_NW), .DW(LEN_W), .QW(QV)) u_div_vax (
		.clk(clk), .en(en), .num(nvax_sC), .den(len_sC), .quo(dvax_d)
	);
	ecc_div #(.NW(V_NW), .DW(LEN_W), .QW(QV)) u_div_vay (
		.clk(clk), .en(en), .num(nvay_sC), .den(len_sC), .quo(dvay_d)
	);
	ecc_div #(.NW(V_NW), .DW(LEN_W), .QW(QV)) u_div_vbx (
		.clk(clk), .en(en), .num(nvbx_sC), .den(len_sC), .quo(dvbx_d)
	);
	ecc_div #(.NW(V_NW), .DW(LEN_W), .QW(QV)) u_div_vby (
		.clk(clk), .en(en), .num(nvby_sC), .den(len_sC), .quo(dvby_d)
	);
	ecc_div #(.NW(SH_NW), .DW(LEN_W+1), .QW(QV)) u_div_shx (
		.clk(clk), .en(en), .num(nsx_sC), .den(len2_sC), .quo(shx_d)
	);
	ecc_div #(.NW(SH_NW), .DW(LEN_W+1), .QW(QV)) u_div_shy (
		.clk(clk), .en(en), .num(nsy_sC), .den(len2_sC), .quo(shy_d)
	);

	ecc_delay #(.W(WD), .N(D2)) u_dly_d (
		.clk (clk),
		.en  (en),
		.din ({raw_sC, coll_sC}),
		.dout(sbd_out)
	);
	assign {raw_d, coll_d} = sbd_out;

	// Final: apply corrections, saturate, or pass the circles through
	logic [CW-1:0] ipx_a, ipy_a, ivx_a, ivy_a, ipx_b, ipy_b, ivx_b, ivy_b;
	logic [CW-1:0] opx_a, opy_a, ovx_a, ovy_a, opx_b, opy_b, ovx_b, ovy_b;
	logic [OW-1:0] res_c;

	assign {ivy_b, ivx_b, ipy_b, ipx_b, ivy_a, ivx_a, ipy_a, ipx_a} = raw_d;

	always_comb begin
		if (coll_d) begin
			opx_a = sat_c($signed({{(FW-CW){ipx_a[CW-1]}}, ipx_a}) - {shx_d[QV], shx_d});
			opy_a = sat_c($signed({{(FW-CW){ipy_a[CW-1]}}, ipy_a}) - {shy_d[QV], shy_d});
			ovx_a = sat_c($signed({{(FW-CW){ivx_a[CW-1]}}, ivx_a}) + {dvax_d[QV], dvax_d});
			ovy_a = sat_c($signed({{(FW-CW){ivy_a[CW-1]}}, ivy_a}) + {dvay_d[QV], dvay_d});
			opx_b = sat_c($signed({{(FW-CW){ipx_b[CW-1]}}, ipx_b}) + {shx_d[QV], shx_d});
			opy_b = sat_c($signed({{(FW-CW){ipy_b[CW-1]}}, ipy_b}) + {shy_d[QV], shy_d});
			ovx_b = sat_c($signed({{(FW-CW){ivx_b[CW-1]}}, ivx_b}) - {dvbx_d[QV], dvbx_d});
			ovy_b = sat_c($signed({{(FW-CW){ivy_b[CW-1]}}, ivy_b}) - {dvby_d[QV], dvby_d});
		end else begin
			opx_a = ipx_a;
			opy_a = ipy_a;
			ovx_a = ivx_a;
			ovy_a = ivy_a;
			opx_b = ipx_b;
			opy_b = ipy_b;
			ovx_b = ivx_b;
			ovy_b = ivy_b;
		end
		res_c = {7'b0, ovy_b, ovx_b, opy_b, opx_b, ovy_a, ovx_a, opy_a, opx_a, coll_d};
	end

	ecc_outbuf #(.W(OW)) u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (en && vld_q[NLAT-1]),
		.push_data(res_c),
		.room     (en),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== hdl/ecc_checker.sv =====
// Port-level checks for the circle collision block, bound to its top level.
module ecc_checker #(
	parameter int COORD_WIDTH = 24
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [8*COORD_WIDTH+7:0]  m_tdata
);

	// Hold a stalled result
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("stalled result changed");

	// Input backpressure only with a result waiting
	a_full_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// A full buffer stays full until drained
	a_full_stays: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready && !m_tready |=> !s_tready)
		else $error("buffer freed without a read");

	// A taken result frees room for input
	a_read_frees: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> s_tready)
		else $error("no room after a read");

endmodule

bind elastic_circle_collision ecc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ecc_checker (.*);
